// ----- design/mfmd_pkg.sv -----
package mfmd_pkg;

    // Encoder counts per rotor revolution
    localparam int unsigned RESOLUTION = 8192;

    localparam logic signed [13:0] C_CENTRE_OFFSET = 14'sd4095;
    localparam logic signed [39:0] C_TURN_STEP     = 40'(RESOLUTION);

    // Reciprocals for exact floor division: floor(v / d) = (v * M) >> k
    localparam logic [22:0] C_RECIP_9 = 23'd7456541;
    localparam int unsigned C_SHIFT_9 = 26;
    localparam logic [22:0] C_RECIP_3 = 23'd2796203;
    localparam int unsigned C_SHIFT_3 = 23;

    typedef enum logic {
        OP_FRAME  = 1'b0,
        OP_REBASE = 1'b1
    } t_op;

    typedef struct packed {
        logic signed [31:0] turns;
        logic signed [39:0] position;
    } t_track;

endpackage

// ----- design/mfmd_speed_scale.sv -----
module mfmd_speed_scale (
    input  logic               i_motor_type,
    input  logic signed [15:0] i_speed,
    output logic signed [19:0] o_axis_rpm_q8
);

    logic [15:0] mag;
    logic [21:0] v_36;
    logic [21:0] v_192;
    logic [21:0] v_sel;
    logic [22:0] recip;
    logic [44:0] prod;
    logic [19:0] quot;

    // Rounded quotient as floor((64*mag + 4) / 9) or floor((40*mag + 1) / 3)
    assign mag   = (i_speed < 0) ? 16'(-i_speed) : 16'(i_speed);
    assign v_36  = {mag, 6'b0} + 22'd4;
    assign v_192 = (22'(mag) << 5) + (22'(mag) << 3) + 22'd1;
    assign v_sel = i_motor_type ? v_192 : v_36;
    assign recip = i_motor_type ? mfmd_pkg::C_RECIP_3 : mfmd_pkg::C_RECIP_9;
    assign prod  = 45'(v_sel) * 45'(recip);
    assign quot  = i_motor_type ? 20'(prod >> mfmd_pkg::C_SHIFT_3)
                                : 20'(prod >> mfmd_pkg::C_SHIFT_9);

    assign o_axis_rpm_q8 = (i_speed < 0) ? -$signed(quot) : $signed(quot);

endmodule

// ----- design/mfmd_unwrap.sv -----
module mfmd_unwrap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  mfmd_pkg::t_op      i_op,
    input  logic [12:0]        i_angle,
    input  logic signed [15:0] i_speed,
    output mfmd_pkg::t_track   o_next
);

    logic signed [13:0] r_prev_angle;
    logic signed [31:0] r_turns;
    logic signed [39:0] r_position;
    logic               r_baseline;

    logic signed [13:0] centred;
    logic               now_pos;
    logic               was_pos;
    logic               turn_up;
    logic               turn_dn;
    logic signed [39:0] turn_term;
    logic signed [39:0] diff;
    logic signed [31:0] n_turns;
    logic signed [39:0] n_position;

    assign centred = $signed({1'b0, i_angle}) - mfmd_pkg::C_CENTRE_OFFSET;
    assign now_pos = centred > 0;
    assign was_pos = r_prev_angle > 0;
    assign turn_up = was_pos && !now_pos && (i_speed > 0);
    assign turn_dn = !was_pos && now_pos && (i_speed < 0);

    // Last unwrapped count always equals turns * RESOLUTION + previous angle,
    // so the change is the turn step plus the angle change.
    assign turn_term = turn_up ? mfmd_pkg::C_TURN_STEP :
                       turn_dn ? -mfmd_pkg::C_TURN_STEP : 40'sd0;
    assign diff      = turn_term + 40'(centred) - 40'(r_prev_angle);

    assign n_turns    = turn_up ? r_turns + 32'sd1 :
                        turn_dn ? r_turns - 32'sd1 : r_turns;
    assign n_position = r_baseline ? r_position : r_position + diff;

    assign o_next.turns    = n_turns;
    assign o_next.position = n_position;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_angle <= '0;
            r_turns      <= '0;
            r_position   <= '0;
            r_baseline   <= 1'b1;
        end else if (i_step) begin
            if (i_op == mfmd_pkg::OP_REBASE) begin
                r_baseline <= 1'b1;
            end else begin
                r_prev_angle <= centred;
                r_turns      <= n_turns;
                r_position   <= n_position;
                r_baseline   <= 1'b0;
            end
        end
    end

endmodule

// ----- design/motor_feedback_multiturn_decoder_top.sv -----
// From input accept to result valid: input register, then result register. Throughput:
// one item per cycle unless stalled; a rebaseline item takes a slot and gives no result.
// The input register holds while a result waits under stall, so the block keeps
// accepting until both registers are full.
// Reset (synchronous, active low): clears valids, turns, position and angle,
// sets the rebaseline flag and selects ratio 36.
module motor_feedback_multiturn_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [12:0]        i_angle_raw,
    input  logic signed [15:0] i_speed_raw,
    input  logic signed [15:0] i_current_raw,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [19:0] o_axis_rpm_q8,
    output logic signed [39:0] o_position_counts,
    output logic signed [31:0] o_turns,
    output logic signed [15:0] o_current_value
);

    logic               r_motor_type;
    logic               r_s1_valid;
    mfmd_pkg::t_op      r_s1_op;
    logic [12:0]        r_s1_angle;
    logic signed [15:0] r_s1_speed;
    logic signed [15:0] r_s1_current;
    logic               r_out_valid;
    logic signed [19:0] r_axis_rpm;
    logic signed [39:0] r_position;
    logic signed [31:0] r_turns;
    logic signed [15:0] r_current;

    logic               s1_go;
    logic               s1_fire;
    logic               s1_frame;
    logic signed [19:0] axis_rpm;
    mfmd_pkg::t_track   track_next;

    assign s1_go      = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && s1_go;
    assign s1_frame   = r_s1_op == mfmd_pkg::OP_FRAME;
    assign o_in_stall = r_s1_valid && !s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_type <= 1'b0;
        end else if (i_cfg_we) begin
            r_motor_type <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_op      <= mfmd_pkg::t_op'(i_op);
            r_s1_angle   <= i_angle_raw;
            r_s1_speed   <= i_speed_raw;
            r_s1_current <= i_current_raw;
        end
    end

    mfmd_speed_scale u_speed (
        .i_motor_type  (r_motor_type),
        .i_speed       (r_s1_speed),
        .o_axis_rpm_q8 (axis_rpm)
    );

    mfmd_unwrap u_unwrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_fire),
        .i_op    (r_s1_op),
        .i_angle (r_s1_angle),
        .i_speed (r_s1_speed),
        .o_next  (track_next)
    );

    // Drop rebaseline items here: they leave no result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= r_s1_valid && s1_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_frame) begin
            r_axis_rpm <= axis_rpm;
            r_position <= track_next.position;
            r_turns    <= track_next.turns;
            r_current  <= r_s1_current;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_axis_rpm_q8     = r_axis_rpm;
    assign o_position_counts = r_position;
    assign o_turns           = r_turns;
    assign o_current_value   = r_current;

    a_rebase_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !s1_frame) |=> !o_out_valid)
        else $error("rebaseline item produced a result");

    a_frame_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_frame) |=> o_out_valid)
        else $error("feedback frame lost between stages");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && o_out_valid && i_out_stall))
        else $error("input stalled while a stage was free");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("valid state not cleared by reset");

endmodule

// ----- sim/mfmd_track_checker.sv -----
module mfmd_track_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_op,
    input  logic [12:0]        i_angle_raw,
    input  logic signed [15:0] i_speed_raw,
    input  logic signed [15:0] i_current_raw,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [19:0] i_axis_rpm_q8,
    input  logic signed [39:0] i_position_counts,
    input  logic signed [31:0] i_turns,
    input  logic signed [15:0] i_current_value,
    output int                 o_mismatches,
    output int                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [19:0] rpm_q8;
        logic signed [39:0] position;
        logic signed [31:0] turns;
        logic signed [15:0] current;
    } t_reading;

    t_reading pending_readings[$];

    // shaft tracking state
    logic               ratio_19_2;
    logic signed [13:0] last_centred;
    logic signed [31:0] rev_count;
    logic signed [47:0] last_unwrap;
    logic signed [39:0] shaft_position;
    logic               rebase_pending;

    int mismatches = 0;
    int outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    task automatic reset_tracking();
        ratio_19_2     = 1'b0;
        last_centred   = '0;
        rev_count      = '0;
        last_unwrap    = '0;
        shaft_position = '0;
        rebase_pending = 1'b1;
    endtask

    // Advance the turn counter and position by one frame and form its reading.
    task automatic track_frame(input logic [12:0] angle, input logic signed [15:0] speed,
                               input logic signed [15:0] current, output t_reading rd);
        int                 centred;
        int                 mag;
        int                 num;
        int                 den;
        int                 q;
        logic signed [47:0] unwrap;
        centred = int'(angle) - 4095;
        if (last_centred > 0 && centred <= 0 && speed > 0) begin
            rev_count = rev_count + 32'sd1;
        end else if (last_centred <= 0 && centred > 0 && speed < 0) begin
            rev_count = rev_count - 32'sd1;
        end
        last_centred = 14'(centred);
        unwrap = 48'(longint'(rev_count) * longint'(mfmd_pkg::RESOLUTION)
                     + longint'(centred));
        if (rebase_pending) begin
            rebase_pending = 1'b0;
        end else begin
            shaft_position = shaft_position + 40'(unwrap - last_unwrap);
        end
        last_unwrap = unwrap;

        // rpm / 36 is rpm * 64 / 9 in Q8, rpm / 19.2 is rpm * 40 / 3; round to nearest
        mag = (speed < 0) ? -int'(speed) : int'(speed);
        num = ratio_19_2 ? 40 : 64;
        den = ratio_19_2 ? 3 : 9;
        q   = (mag * num * 2 + den) / (2 * den);
        if (speed < 0) begin
            q = -q;
        end
        rd.rpm_q8   = 20'(q);
        rd.position = shaft_position;
        rd.turns    = rev_count;
        rd.current  = current;
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            note_mismatch(what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        t_reading got;
        if (!i_rst_n) begin
            reset_tracking();
            pending_readings.delete();
        end else begin
            if (i_cfg_we) begin
                ratio_19_2 = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_readings.size() == 0) begin
                    note_mismatch("unexpected item, position", 0, i_position_counts);
                end else begin
                    want = pending_readings.pop_front();
                    check_field("axis_rpm_q8", want.rpm_q8, i_axis_rpm_q8);
                    check_field("position_counts", want.position, i_position_counts);
                    check_field("turns", want.turns, i_turns);
                    check_field("current_value", want.current, i_current_value);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (mfmd_pkg::t_op'(i_op) == mfmd_pkg::OP_REBASE) begin
                    rebase_pending = 1'b1;
                end else begin
                    track_frame(i_angle_raw, i_speed_raw, i_current_raw, got);
                    pending_readings.push_back(got);
                end
            end
        end
        outstanding <= pending_readings.size();
    end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic RATIO_36   = 1'b0;
    localparam logic RATIO_19_2 = 1'b1;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 120;
    localparam int PHASE_ITEMS   = 250;
    localparam int LATENCY_SLACK = 4;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_data    = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               i_op          = 1'b0;
    logic [12:0]        i_angle_raw   = '0;
    logic signed [15:0] i_speed_raw   = '0;
    logic signed [15:0] i_current_raw = '0;
    logic               i_out_stall   = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [19:0] o_axis_rpm_q8;
    logic signed [39:0] o_position_counts;
    logic signed [31:0] o_turns;
    logic signed [15:0] o_current_value;

    int mismatches;
    int outstanding;

    int idle_pct   = 12;
    int hold_token = 0;
    int hold_seen  = 0;
    int cycle_count = 0;

    // simulated rotor for well-formed rotation sequences
    int shaft_angle = 0;
    int shaft_dir   = 1;

    always #2 i_clk = ~i_clk;

    motor_feedback_multiturn_decoder_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_angle_raw       (i_angle_raw),
        .i_speed_raw       (i_speed_raw),
        .i_current_raw     (i_current_raw),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_axis_rpm_q8     (o_axis_rpm_q8),
        .o_position_counts (o_position_counts),
        .o_turns           (o_turns),
        .o_current_value   (o_current_value)
    );

    mfmd_track_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_angle_raw       (i_angle_raw),
        .i_speed_raw       (i_speed_raw),
        .i_current_raw     (i_current_raw),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_axis_rpm_q8     (o_axis_rpm_q8),
        .i_position_counts (o_position_counts),
        .i_turns           (o_turns),
        .i_current_value   (o_current_value),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stall, or a long hold-off when requested.
    initial begin
        forever begin
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                repeat (HOLD_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                i_out_stall <= ($urandom_range(99) < idle_pct);
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input mfmd_pkg::t_op op, input logic [12:0] angle,
                             input logic [15:0] speed, input logic [15:0] current);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_angle_raw   <= angle;
        i_speed_raw   <= speed;
        i_current_raw <= current;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and hold until every reading is back and the pipe is empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    task automatic write_ratio(input logic ratio);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= ratio;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_random();
        int pick;
        int step;
        int spd;
        pick = $urandom_range(99);
        if (pick < 3) begin
            send_item(mfmd_pkg::OP_REBASE, 13'($urandom), 16'($urandom), 16'($urandom));
        end else if (pick < 15) begin
            send_item(mfmd_pkg::OP_FRAME, 13'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            if ($urandom_range(39) == 0) begin
                shaft_dir = -shaft_dir;
            end
            step = $urandom_range(1200, 1);
            shaft_angle = (shaft_angle + shaft_dir * step) & 8191;
            spd = $urandom_range(32767, 1);
            spd = shaft_dir * spd;
            send_item(mfmd_pkg::OP_FRAME, 13'(shaft_angle), 16'(spd), 16'($urandom));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ratio 36 from reset: angle extremes, centre crossings, rebaseline
        send_item(mfmd_pkg::OP_FRAME, 13'd0, 16'h7FFF, 16'h7FFF);
        send_item(mfmd_pkg::OP_FRAME, 13'd8191, 16'h8000, 16'h8000);
        send_item(mfmd_pkg::OP_FRAME, 13'd4095, 16'h0000, 16'h0000);
        send_item(mfmd_pkg::OP_FRAME, 13'd4096, 16'hFFFF, 16'h0001);
        send_item(mfmd_pkg::OP_FRAME, 13'd4095, 16'h0001, 16'hFFFF);
        send_item(mfmd_pkg::OP_FRAME, 13'd8191, 16'd100, 16'h5555);
        send_item(mfmd_pkg::OP_FRAME, 13'd0, 16'd100, 16'hAAAA);
        send_item(mfmd_pkg::OP_REBASE, 13'($urandom), 16'($urandom), 16'($urandom));
        send_item(mfmd_pkg::OP_FRAME, 13'd6000, 16'd5, 16'd3);
        send_item(mfmd_pkg::OP_REBASE, 13'($urandom), 16'($urandom), 16'($urandom));
        send_item(mfmd_pkg::OP_REBASE, 13'($urandom), 16'($urandom), 16'($urandom));
        send_item(mfmd_pkg::OP_FRAME, 13'd100, -16'sd200, 16'd7);
        send_item(mfmd_pkg::OP_FRAME, 13'd8191, -16'sd300, 16'd8);
        send_item(mfmd_pkg::OP_FRAME, 13'd4096, 16'd0, 16'd9);

        write_ratio(RATIO_19_2);
        send_item(mfmd_pkg::OP_FRAME, 13'd0, 16'h7FFF, 16'd1);
        send_item(mfmd_pkg::OP_FRAME, 13'd1, 16'h8000, 16'd2);
        send_item(mfmd_pkg::OP_FRAME, 13'd2, 16'h0001, 16'd3);
        send_item(mfmd_pkg::OP_FRAME, 13'd3, 16'hFFFF, 16'd4);
        send_item(mfmd_pkg::OP_FRAME, 13'd4, 16'h0000, 16'd5);
        send_item(mfmd_pkg::OP_FRAME, 13'd8191, 16'd3, 16'd6);

        for (int phase = 0; phase < 6; phase++) begin
            write_ratio((phase % 2 == 0) ? RATIO_36 : RATIO_19_2);
            idle_pct = (phase == 2) ? 0 : 12;
            if (phase == 3) begin
                hold_token++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random();
            end
        end
        idle_pct = 12;

        wait_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
